[design/b64dp_pkg.sv]
// package for the base64 decoder with a configurable pad character
// holds the field widths, status codes, the result bundle and the alphabet map
// no dependencies
package b64dp_pkg;

    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned VAL_W    = 6;
    localparam int unsigned LEN_W    = 11;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned CNT_W    = 2;
    localparam int unsigned LEN_MAX  = (1 << LEN_W) - 1;

    // register indexes on the configuration port
    localparam logic REG_PAD_CHAR  = 1'b0;
    localparam logic REG_MAX_BYTES = 1'b1;

    // register reset values
    localparam logic [CHAR_W-1:0] PAD_CHAR_RESET  = 8'h2d;
    localparam logic [LEN_W-1:0]  MAX_BYTES_RESET = 11'd1024;
    localparam int unsigned       MAX_BYTES_DEFAULT = 1024;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_CHAR = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TOO_LONG = 2'd2;

    // all the results one input word gives, in output order
    typedef struct packed {
        logic [CNT_W-1:0]      n_bytes;    // decoded bytes, 0..3
        logic [2:0][7:0]       bytes;      // bytes[0] goes out first
        logic                  has_status; // closing word without data
        logic [STATUS_W-1:0]   status;
        logic                  str_last;   // this input closes the string
    } t_result_set;

    // alphabet map: bit 6 set for an alphabet character, low bits the value
    function automatic logic [VAL_W:0] char_value(input logic [CHAR_W-1:0] ch);
        logic [VAL_W:0] res;
        res = '0;
        if (ch >= 8'h41 && ch <= 8'h5a) begin
            res = {1'b1, VAL_W'(ch - 8'h41)};
        end else if (ch >= 8'h61 && ch <= 8'h7a) begin
            res = {1'b1, VAL_W'(ch - 8'h61 + 8'd26)};
        end else if (ch >= 8'h30 && ch <= 8'h39) begin
            res = {1'b1, VAL_W'(ch - 8'h30 + 8'd52)};
        end else if (ch == 8'h2b) begin
            res = {1'b1, 6'd62};
        end else if (ch == 8'h2f) begin
            res = {1'b1, 6'd63};
        end
        return res;
    endfunction

endpackage

[design/base64_dash_pad_decoder.sv]
// Streaming base64 decoder taking one character per word, with tlast marking the end of
// the string; characters equal to the pad register (reset '-') are trailing padding. Each
// accepted character gives zero to three output words: decoded bytes, and on the last
// character a closing word with the status when there is an error or no byte came out.
// The character step, flush and length check are one pass of logic between the string
// state and the output register. One word leaves per cycle while the output is ready, so
// a character that yields several words holds the input until its last word leaves, and
// characters yielding at most one word stream at one per cycle. After an error the rest
// of the string is swallowed up to its last character. Registers: 0 pad character, 1 length
// limit (the smaller of it and MAX_OUTPUT_BYTES is used); write them while the block is idle.
// depends on b64dp_pkg, b64dp_core, b64dp_out
module base64_dash_pad_decoder #(
    parameter int unsigned MAX_OUTPUT_BYTES = b64dp_pkg::MAX_BYTES_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration write port
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_addr,
    input  logic [b64dp_pkg::LEN_W-1:0]  i_cfg_wdata,
    // character input
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [7:0]                   i_s_axis_tdata,   // [7:0] in_char
    input  logic                         i_s_axis_tlast,   // in_last
    // decoded output
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    output logic [15:0]                  o_m_axis_tdata,   // [7:0] out_byte, [9:8] status
    output logic [1:0]                   o_m_axis_tuser,   // [0] byte_valid, [1] string_end
    output logic                         o_m_axis_tlast    // run_end
);
    import b64dp_pkg::*;

    t_result_set         set;
    logic                accept;
    logic [7:0]          out_byte;
    logic                byte_valid;
    logic [STATUS_W-1:0] status;
    logic                string_end;

    assign accept = i_s_axis_tvalid && o_s_axis_tready;

    b64dp_core #(
        .MAX_OUTPUT_BYTES (MAX_OUTPUT_BYTES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_char      (i_s_axis_tdata),
        .i_last      (i_s_axis_tlast),
        .i_accept    (accept),
        .o_set       (set)
    );

    b64dp_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_set        (set),
        .i_load       (accept),
        .o_load_ready (o_s_axis_tready),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_byte       (out_byte),
        .o_byte_valid (byte_valid),
        .o_status     (status),
        .o_run_end    (o_m_axis_tlast),
        .o_string_end (string_end)
    );

    // output word packing
    assign o_m_axis_tdata = {6'b0, status, out_byte};
    assign o_m_axis_tuser = {string_end, byte_valid};

endmodule

[design/b64dp_core.sv]
// decode core: configuration registers, group accumulator and string state
// works out the whole result set of one character in a single pass
// depends on b64dp_pkg
module b64dp_core #(
    parameter int unsigned MAX_OUTPUT_BYTES = b64dp_pkg::MAX_BYTES_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_addr,
    input  logic [b64dp_pkg::LEN_W-1:0]   i_cfg_wdata,
    input  logic [b64dp_pkg::CHAR_W-1:0]  i_char,
    input  logic                          i_last,
    input  logic                          i_accept,
    output b64dp_pkg::t_result_set        o_set
);
    import b64dp_pkg::*;

    // build-time cap on the length limit, clipped to the counter range
    localparam logic [LEN_W-1:0] LEN_CAP =
        (MAX_OUTPUT_BYTES > LEN_MAX) ? LEN_W'(LEN_MAX) : LEN_W'(MAX_OUTPUT_BYTES);

    logic [CHAR_W-1:0]   r_pad_char;
    logic [LEN_W-1:0]    r_max_bytes;
    logic [17:0]         r_bits, n_bits;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_pad_seen, n_pad_seen;
    logic [STATUS_W-1:0] r_err, n_err;
    logic [LEN_W-1:0]    r_emitted, n_emitted;

    logic [VAL_W:0]      chv;
    logic [2:0][7:0]     cand;
    logic [CNT_W-1:0]    cand_n;
    logic [LEN_W-1:0]    limit;
    logic [LEN_W-1:0]    avail;
    logic [CNT_W-1:0]    avail_small;
    logic [CNT_W-1:0]    emit_n;
    logic [STATUS_W-1:0] err_out;

    assign chv   = char_value(i_char);
    assign limit = (r_max_bytes < LEN_CAP) ? r_max_bytes : LEN_CAP;
    assign avail = (r_emitted >= limit) ? '0 : limit - r_emitted;
    assign avail_small = (avail > LEN_W'(3)) ? CNT_W'(3) : avail[CNT_W-1:0];

    // character step, end-of-string flush and length check
    always_comb begin
        n_bits     = r_bits;
        n_cnt      = r_cnt;
        n_pad_seen = r_pad_seen;
        err_out    = r_err;
        cand       = '0;
        cand_n     = '0;
        if (r_err == STATUS_OK) begin
            if (i_char == r_pad_char) begin
                n_pad_seen = 1'b1;
            end else if (!chv[VAL_W] || r_pad_seen) begin
                err_out = STATUS_BAD_CHAR;
            end else if (r_cnt == CNT_W'(3)) begin
                cand   = {{r_bits[1:0], chv[VAL_W-1:0]}, r_bits[9:2], r_bits[17:10]};
                cand_n = CNT_W'(3);
                n_bits = '0;
                n_cnt  = '0;
            end else begin
                n_bits = {r_bits[11:0], chv[VAL_W-1:0]};
                n_cnt  = r_cnt + CNT_W'(1);
            end
        end
        // flush of a partial group on the last character
        if (i_last && err_out == STATUS_OK) begin
            case (n_cnt)
                CNT_W'(3): begin
                    cand   = {8'h00, n_bits[9:2], n_bits[17:10]};
                    cand_n = CNT_W'(2);
                end
                CNT_W'(2): begin
                    cand   = {8'h00, 8'h00, n_bits[11:4]};
                    cand_n = CNT_W'(1);
                end
                default: begin
                end
            endcase
        end
        emit_n = (cand_n < avail_small) ? cand_n : avail_small;
        if (emit_n < cand_n) begin
            err_out = STATUS_TOO_LONG;
        end
        n_err     = err_out;
        n_emitted = r_emitted + LEN_W'(emit_n);
    end

    // result bundle for the output stage
    always_comb begin
        o_set.n_bytes    = emit_n;
        o_set.bytes      = cand;
        o_set.has_status = i_last && (err_out != STATUS_OK || emit_n == '0);
        o_set.status     = err_out;
        o_set.str_last   = i_last;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad_char  <= PAD_CHAR_RESET;
            r_max_bytes <= MAX_BYTES_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_PAD_CHAR:  r_pad_char  <= i_cfg_wdata[CHAR_W-1:0];
                REG_MAX_BYTES: r_max_bytes <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // string state, cleared after the last character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits     <= '0;
            r_cnt      <= '0;
            r_pad_seen <= 1'b0;
            r_err      <= STATUS_OK;
            r_emitted  <= '0;
        end else if (i_accept) begin
            if (i_last) begin
                r_bits     <= '0;
                r_cnt      <= '0;
                r_pad_seen <= 1'b0;
                r_err      <= STATUS_OK;
                r_emitted  <= '0;
            end else begin
                r_bits     <= n_bits;
                r_cnt      <= n_cnt;
                r_pad_seen <= n_pad_seen;
                r_err      <= n_err;
                r_emitted  <= n_emitted;
            end
        end
    end

endmodule

[design/b64dp_out.sv]
// output stage: holds one character's result set and sends its words one per
// cycle while ready; takes a new set when empty or as the final word leaves
// depends on b64dp_pkg
module b64dp_out (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  b64dp_pkg::t_result_set       i_set,
    input  logic                         i_load,
    output logic                         o_load_ready,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [7:0]                   o_byte,
    output logic                         o_byte_valid,
    output logic [b64dp_pkg::STATUS_W-1:0] o_status,
    output logic                         o_run_end,
    output logic                         o_string_end
);
    import b64dp_pkg::*;

    t_result_set      r_set;
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] r_total;
    logic             is_final;
    logic             is_byte;

    assign o_valid      = (r_idx != r_total);
    assign is_final     = (r_idx == r_total - CNT_W'(1));
    assign o_load_ready = !o_valid || (i_ready && is_final);
    assign is_byte      = (r_idx < r_set.n_bytes);

    // word fields for the current position
    always_comb begin
        o_byte = 8'h00;
        if (is_byte) begin
            case (r_idx)
                CNT_W'(0): o_byte = r_set.bytes[0];
                CNT_W'(1): o_byte = r_set.bytes[1];
                default:   o_byte = r_set.bytes[2];
            endcase
        end
        o_byte_valid = is_byte;
        o_status     = is_byte ? STATUS_OK : r_set.status;
        o_run_end    = is_final;
        o_string_end = is_final && r_set.str_last;
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_set <= i_set;
        end
    end

    // position within the result set
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_total <= '0;
        end else if (i_load) begin
            r_idx   <= '0;
            r_total <= i_set.n_bytes + CNT_W'(i_set.has_status);
        end else if (o_valid && i_ready) begin
            r_idx <= r_idx + CNT_W'(1);
        end
    end

endmodule
